// File: rtl/core/tcaf_pkg.sv
// ----------------------------------------------------------------------------
// tcaf_pkg
// Shared constants and operation/status codes for the two-class
// age-ordered FIFO.
// ----------------------------------------------------------------------------
package tcaf_pkg;

  // default sizing
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int SEQ_BITS_DEF    = 32;

  // fixed field widths
  localparam int ID_W     = 16;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ENQ     = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DEQ_ANY = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DEQ_C1  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DEQ_C0  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

endpackage

// File: rtl/core/tcaf_ram.sv
// ----------------------------------------------------------------------------
// tcaf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcaf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/two_class_age_ordered_fifo.sv
// Timing: an accepted input is captured into the operation registers and
//   S_EXEC; the result register loads once no earlier result holds it.
// Flow: one item in flight; a new input is taken only back in S_IDLE,
//   after the previous item's result has been loaded for output.
// Reset: synchronous; clears pointers, counts, the arrival counter and the
//   handshake state. Queue RAM contents are left as they are.
// ----------------------------------------------------------------------------
// two_class_age_ordered_fifo
// Two FIFOs, one per item class, held in block RAM. Each entry stores an
// item id and its arrival sequence number; "dequeue oldest" compares the
// two heads with serial arithmetic.
// ----------------------------------------------------------------------------
module two_class_age_ordered_fifo #(
  parameter int QUEUE_DEPTH = tcaf_pkg::QUEUE_DEPTH_DEF,
  parameter int SEQ_BITS    = tcaf_pkg::SEQ_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tcaf_pkg::FUNC_W-1:0]     func,
  input  logic [tcaf_pkg::ID_W-1:0]       item_id,
  input  logic                            item_class,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcaf_pkg::STATUS_W-1:0]   status,
  output logic [tcaf_pkg::ID_W-1:0]       out_id,
  output logic                            out_class
);

  import tcaf_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = SEQ_BITS + ID_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  // queue pointers and occupancy
  logic [AW-1:0]       head0, head1, tail0, tail1;
  logic [AW-1:0]       head0_next, head1_next, tail0_next, tail1_next;
  logic [CW-1:0]       count0, count1;
  logic [CW-1:0]       count0_next, count1_next;
  logic [SEQ_BITS-1:0] arrival, arrival_next;

  // captured operation
  logic [FUNC_W-1:0]   op_func;
  logic [ID_W-1:0]     op_id;
  logic                op_class;

  // RAM ports
  logic                we0, we1;
  logic [EW-1:0]       wdata;
  logic [EW-1:0]       rdata0, rdata1;

  // execute-stage decisions
  logic                fire;
  logic [STATUS_W-1:0] res_status;
  logic                do_pop;
  logic                pick;
  logic                do_push;
  logic                empty0, empty1;
  logic [SEQ_BITS-1:0] seq0, seq1, seq_diff;
  logic [ID_W-1:0]     res_id;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // one item in flight; the result register decouples the output side
  assign in_ready = (state == S_IDLE);
  assign fire     = (state == S_EXEC) && (!out_valid || out_ready);

  // head entries, read continuously at the head pointers
  tcaf_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram0 (
    .clk   (clk),
    .we    (we0),
    .waddr (tail0),
    .wdata (wdata),
    .raddr (head0),
    .rdata (rdata0)
  );

  tcaf_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram1 (
    .clk   (clk),
    .we    (we1),
    .waddr (tail1),
    .wdata (wdata),
    .raddr (head1),
    .rdata (rdata1)
  );

  assign empty0   = (count0 == '0);
  assign empty1   = (count1 == '0);
  assign seq0     = rdata0[ID_W +: SEQ_BITS];
  assign seq1     = rdata1[ID_W +: SEQ_BITS];
  assign seq_diff = seq0 - seq1;
  assign wdata    = {arrival, op_id};

  // operation decode
  always_comb begin
    res_status = ST_EMPTY;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    pick       = 1'b0;
    case (op_func)
      FN_ENQ: begin
        if ((op_class ? count1 : count0) == CW'(QUEUE_DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_ENQUEUED;
          do_push    = 1'b1;
        end
      end
      FN_DEQ_ANY: begin
        if (!(empty0 && empty1)) begin
          res_status = ST_DEQUEUED;
          do_pop     = 1'b1;
          if (empty0) begin
            pick = 1'b1;
          end else if (empty1) begin
            pick = 1'b0;
          end else begin
            // class 0 only when strictly older; ties go to class 1
            pick = !seq_diff[SEQ_BITS-1];
          end
        end
      end
      FN_DEQ_C1: begin
        pick = 1'b1;
        if (!empty1) begin
          res_status = ST_DEQUEUED;
          do_pop     = 1'b1;
        end
      end
      FN_DEQ_C0: begin
        pick = 1'b0;
        if (!empty0) begin
          res_status = ST_DEQUEUED;
          do_pop     = 1'b1;
        end
      end
      default: begin
        res_status = ST_EMPTY;
      end
    endcase
  end

  assign res_id = pick ? rdata1[ID_W-1:0] : rdata0[ID_W-1:0];
  assign we0    = fire && do_push && !op_class;
  assign we1    = fire && do_push && op_class;

  // pointer and count updates
  always_comb begin
    head0_next   = head0;
    head1_next   = head1;
    tail0_next   = tail0;
    tail1_next   = tail1;
    count0_next  = count0;
    count1_next  = count1;
    arrival_next = arrival;
    if (fire && do_push) begin
      arrival_next = arrival + SEQ_BITS'(1);
      if (op_class) begin
        tail1_next  = ptr_inc(tail1);
        count1_next = count1 + CW'(1);
      end else begin
        tail0_next  = ptr_inc(tail0);
        count0_next = count0 + CW'(1);
      end
    end
    if (fire && do_pop) begin
      if (pick) begin
        head1_next  = ptr_inc(head1);
        count1_next = count1 - CW'(1);
      end else begin
        head0_next  = ptr_inc(head0);
        count0_next = count0 - CW'(1);
      end
    end
  end

  // control state, queue state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      head0     <= '0;
      head1     <= '0;
      tail0     <= '0;
      tail1     <= '0;
      count0    <= '0;
      count1    <= '0;
      arrival   <= '0;
    end else begin
      head0   <= head0_next;
      head1   <= head1_next;
      tail0   <= tail0_next;
      tail1   <= tail1_next;
      count0  <= count0_next;
      count1  <= count1_next;
      arrival <= arrival_next;
      // result valid: load on fire, clear once taken
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_func  <= func;
      op_id    <= item_id;
      op_class <= item_class;
    end
    if (fire) begin
      status    <= res_status;
      out_id    <= do_pop ? res_id : '0;
      out_class <= do_pop ? pick : 1'b0;
    end
  end

endmodule

// File: rtl/core/tcaf_checker.sv
// ----------------------------------------------------------------------------
// tcaf_checker
// Port-level checks for the two-class age-ordered FIFO, bound to the top.
// ----------------------------------------------------------------------------
module tcaf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcaf_pkg::STATUS_W-1:0] status,
  input logic [tcaf_pkg::ID_W-1:0]     out_id,
  input logic                          out_class
);

  import tcaf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_id)
      && $stable(out_class))
    else $error("result changed while stalled");

  // only a dequeue carries an id and class
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DEQUEUED |-> out_id == '0 && out_class == 1'b0)
    else $error("non-dequeue result with nonzero payload");

  // one item in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind two_class_age_ordered_fifo tcaf_checker u_tcaf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .out_id    (out_id),
  .out_class (out_class)
);
